/* src/dmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and constants of the duration median profiler.
// ----------------------------------------------------------------------------
package dmp_pkg;

    localparam int SAMPLE_DEPTH = 512;
    localparam int WARMUP_SKIP  = 10;
    localparam int SLOT_COUNT   = 3;

    localparam int SLOT_W  = 2;
    localparam int IDX_W   = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W   = $clog2(SAMPLE_DEPTH + 1);
    localparam int ADDR_W  = SLOT_W + IDX_W;
    localparam int MEM_D   = SLOT_COUNT * SAMPLE_DEPTH;
    localparam int NUM_W   = 64 + 10 + 16;
    localparam int STEP_W  = $clog2(NUM_W + 1);

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic CFG_PROF = 1'b0;
    localparam logic CFG_FREQ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV,
        ST_UPDATE,
        ST_SEL_INIT,
        ST_SEL_READ,
        ST_SEL_BIT,
        ST_SEL_SAVE,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CHECK,
        CMD_MUL_A,
        CMD_MUL_B,
        CMD_DIV,
        CMD_UPDATE,
        CMD_SEL_INIT,
        CMD_SEL_READ,
        CMD_SEL_BIT,
        CMD_SEL_SAVE,
        CMD_RESULT
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic slot_ok;
        logic ok;
        logic usable_zero;
        logic div_done;
        logic read_done;
        logic last_bit;
        logic need_second;
        logic out_free;
    } t_status;

endpackage

/* src/duration_median_profiler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_median_profiler_unit
// Per-slot timing statistics with warmup-skipping median query.
//
//   channel  direction  handshake              payload
//   in       sink       i_in_valid/o_in_stall  op, slot, start/end tick, disjoint
//   out      source     o_out_valid/i_out_stall accepted, median, counts, total
//   cfg      sink       i_cfg_valid/o_cfg_ready index, data
//
// One word at a time. A record runs through the 90-step restoring divider.
// A query selects the median bit by bit, reading the usable samples through
// the single sample store read port, in two passes for an even count.
// Synchronous active-low reset clears counts and totals; the sample store
// is not cleared. A finished word waits in the output register under stall.
// ----------------------------------------------------------------------------
module duration_median_profiler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [1:0]  i_slot,
    input  logic [63:0] i_start_tick,
    input  logic [63:0] i_end_tick,
    input  logic        i_disjoint,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [31:0] o_median_ms,
    output logic [9:0]  o_stored_count,
    output logic [31:0] o_measure_count,
    output logic [63:0] o_total_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import dmp_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dmp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_start_tick    (i_start_tick),
        .i_end_tick      (i_end_tick),
        .i_disjoint      (i_disjoint),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_accepted      (o_accepted),
        .o_median_ms     (o_median_ms),
        .o_stored_count  (o_stored_count),
        .o_measure_count (o_measure_count),
        .o_total_ms      (o_total_ms)
    );

endmodule

/* src/dmp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_ctrl
// Sequencer for record conversion and median selection.
// ----------------------------------------------------------------------------
module dmp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  dmp_pkg::t_status i_status,
    output dmp_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);
    import dmp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!i_status.slot_ok) begin
                    n_state = ST_FINISH;
                end else if (i_status.is_query) begin
                    n_state = i_status.usable_zero ? ST_FINISH : ST_SEL_INIT;
                end else begin
                    n_state = i_status.ok ? ST_MUL_A : ST_FINISH;
                end
            end
            ST_MUL_A:    n_state = ST_MUL_B;
            ST_MUL_B:    n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_UPDATE;
            end
            ST_UPDATE:   n_state = ST_FINISH;
            ST_SEL_INIT: n_state = ST_SEL_READ;
            ST_SEL_READ: begin
                if (i_status.read_done) n_state = ST_SEL_BIT;
            end
            ST_SEL_BIT: begin
                if (!i_status.last_bit) begin
                    n_state = ST_SEL_READ;
                end else begin
                    n_state = i_status.need_second ? ST_SEL_SAVE : ST_FINISH;
                end
            end
            ST_SEL_SAVE: n_state = ST_SEL_INIT;
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_cmd = CMD_LOAD;
            end
            ST_CHECK:    o_cmd = CMD_CHECK;
            ST_MUL_A:    o_cmd = CMD_MUL_A;
            ST_MUL_B:    o_cmd = CMD_MUL_B;
            ST_DIV:      o_cmd = CMD_DIV;
            ST_UPDATE:   o_cmd = CMD_UPDATE;
            ST_SEL_INIT: o_cmd = CMD_SEL_INIT;
            ST_SEL_READ: o_cmd = CMD_SEL_READ;
            ST_SEL_BIT:  o_cmd = CMD_SEL_BIT;
            ST_SEL_SAVE: o_cmd = CMD_SEL_SAVE;
            ST_FINISH: begin
                if (i_status.out_free) o_cmd = CMD_RESULT;
            end
            default:     o_cmd = CMD_NONE;
        endcase
    end

endmodule

/* src/dmp_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_dpath
// Conversion divider, slot statistics, sample store, radix median select.
// ----------------------------------------------------------------------------
module dmp_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dmp_pkg::t_cmd             i_cmd,
    output dmp_pkg::t_status          o_status,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_index,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_op,
    input  logic [1:0]                i_slot,
    input  logic [63:0]               i_start_tick,
    input  logic [63:0]               i_end_tick,
    input  logic                      i_disjoint,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_accepted,
    output logic [31:0]               o_median_ms,
    output logic [9:0]                o_stored_count,
    output logic [31:0]               o_measure_count,
    output logic [63:0]               o_total_ms
);
    import dmp_pkg::*;

    logic               r_prof;
    logic [31:0]        r_freq;
    logic               r_op;
    logic [SLOT_W-1:0]  r_slot;
    logic [63:0]        r_start;
    logic [63:0]        r_end;
    logic               r_dis;
    logic [63:0]        r_delta;
    logic [NUM_W-1:0]   r_num;
    logic [31:0]        r_rem;
    logic [31:0]        r_quo;
    logic               r_sat;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_stored [SLOT_COUNT];
    logic [31:0]        r_meas   [SLOT_COUNT];
    logic [63:0]        r_total  [SLOT_COUNT];
    logic [31:0]        r_mem    [MEM_D];
    logic [31:0]        r_rdata;
    logic               r_rd_vld;
    logic [CNT_W-1:0]   r_ridx;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_k;
    logic [4:0]         r_bit;
    logic [31:0]        r_val;
    logic [31:0]        r_lo;
    logic               r_pass;
    logic               r_out_valid;

    logic               slot_ok;
    logic               ok;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   first;
    logic [CNT_W-1:0]   usable;
    logic [CNT_W-1:0]   half;
    logic [32:0]        trial;
    logic               qbit;
    logic [31:0]        value;
    logic [64:0]        sum;
    logic [31:0]        cand;
    logic [CNT_W-1:0]   ridx_abs;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [32:0]        avg;
    logic [31:0]        median;

    assign slot_ok  = (32'(r_slot) < 32'(SLOT_COUNT));
    assign ok       = slot_ok && r_prof && !r_dis && (r_end >= r_start) && (r_freq != 32'd0);
    assign count    = slot_ok ? r_stored[r_slot] : '0;
    assign first    = (count > CNT_W'(WARMUP_SKIP)) ? CNT_W'(WARMUP_SKIP) : '0;
    assign usable   = count - first;
    assign half     = usable >> 1;
    assign trial    = {r_rem, r_num[NUM_W-1]};
    assign qbit     = (trial >= {1'b0, r_freq});
    assign value    = r_sat ? 32'hFFFF_FFFF : r_quo;
    assign sum      = {1'b0, r_total[r_slot]} + {33'd0, value};
    assign cand     = r_val | ((32'd1 << r_bit) - 32'd1);
    assign ridx_abs = first + r_ridx;
    assign rd_addr  = {r_slot, ridx_abs[IDX_W-1:0]};
    assign wr_addr  = {r_slot, count[IDX_W-1:0]};
    assign avg      = ({1'b0, r_lo} + {1'b0, r_val}) >> 1;
    assign median   = (r_op == OP_QUERY && usable != '0) ?
                      (usable[0] ? r_val : avg[31:0]) : 32'd0;

    always_comb begin
        o_status.is_query    = (r_op == OP_QUERY);
        o_status.slot_ok     = slot_ok;
        o_status.ok          = ok;
        o_status.usable_zero = (usable == '0);
        o_status.div_done    = (r_step == '0);
        o_status.read_done   = (r_ridx == usable) && !r_rd_vld;
        o_status.last_bit    = (r_bit == 5'd0);
        o_status.need_second = !usable[0] && !r_pass;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prof <= 1'b0;
            r_freq <= 32'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROF: r_prof <= i_cfg_data[0];
                CFG_FREQ: r_freq <= i_cfg_data;
                default:  r_prof <= r_prof;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_stored[s] <= '0;
                r_meas[s]   <= '0;
                r_total[s]  <= '0;
            end
        end else if (i_cmd == CMD_UPDATE) begin
            r_total[r_slot] <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
            if (r_meas[r_slot] != 32'hFFFF_FFFF) r_meas[r_slot] <= r_meas[r_slot] + 32'd1;
            if (count < CNT_W'(SAMPLE_DEPTH)) r_stored[r_slot] <= count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_UPDATE && count < CNT_W'(SAMPLE_DEPTH)) begin
            r_mem[wr_addr] <= value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op    <= i_op;
                r_slot  <= i_slot;
                r_start <= i_start_tick;
                r_end   <= i_end_tick;
                r_dis   <= i_disjoint;
            end
            CMD_CHECK: r_delta <= r_end - r_start;
            CMD_MUL_A: r_num <= {16'd0, ({r_delta, 10'd0} - {6'd0, r_delta, 4'd0})};
            CMD_MUL_B: begin
                r_num  <= {(r_num[73:0] - {7'd0, r_delta, 3'd0}), 16'd0};
                r_rem  <= 32'd0;
                r_quo  <= 32'd0;
                r_sat  <= 1'b0;
                r_step <= STEP_W'(NUM_W);
            end
            CMD_DIV: begin
                if (r_step != '0) begin
                    r_num  <= r_num << 1;
                    r_rem  <= qbit ? 32'(trial - {1'b0, r_freq}) : trial[31:0];
                    r_quo  <= {r_quo[30:0], qbit};
                    r_sat  <= r_sat | r_quo[31];
                    r_step <= r_step - STEP_W'(1);
                end
            end
            CMD_SEL_INIT: begin
                r_val <= 32'd0;
                r_bit <= 5'd31;
                r_cnt <= '0;
                r_ridx <= '0;
                r_k   <= (r_pass || usable[0]) ? half : half - CNT_W'(1);
            end
            CMD_SEL_READ: begin
                if (r_ridx != usable) begin
                    r_ridx <= r_ridx + CNT_W'(1);
                end
                if (r_rd_vld && r_rdata <= cand) r_cnt <= r_cnt + CNT_W'(1);
            end
            CMD_SEL_BIT: begin
                if (r_cnt <= r_k) r_val <= r_val | (32'd1 << r_bit);
                r_cnt  <= '0;
                r_ridx <= '0;
                if (r_bit != 5'd0) r_bit <= r_bit - 5'd1;
            end
            CMD_SEL_SAVE: r_lo <= r_val;
            default: r_delta <= r_delta;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_pass   <= 1'b0;
        end else begin
            r_rd_vld <= (i_cmd == CMD_SEL_READ) && (r_ridx != usable);
            if (i_cmd == CMD_LOAD) r_pass <= 1'b0;
            else if (i_cmd == CMD_SEL_SAVE) r_pass <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_RESULT) begin
            o_accepted      <= (r_op == OP_RECORD) && ok;
            o_median_ms     <= slot_ok ? median : 32'd0;
            o_stored_count  <= slot_ok ? 10'(count) : 10'd0;
            o_measure_count <= slot_ok ? r_meas[r_slot] : 32'd0;
            o_total_ms      <= slot_ok ? r_total[r_slot] : 64'd0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
